>>> hdl/smfi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smfi_pkg
// Shared types and constants of the streaming first-occurrence key search.
// ----------------------------------------------------------------------------
package smfi_pkg;

  // Default values of the top-level parameters.
  localparam int KEY_MAX_BYTES_DEF = 16;
  localparam int POSITION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int LEN_BITS      = 5;
  localparam int POS_OUT_BITS  = 16;
  localparam int KEY_WORD_BITS = 64;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 5;

  // Register index, taken from the address bits above the 8-byte word offset.
  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2
  } reg_idx_t;

  // Configuration handed from the register file to the search core.
  typedef struct packed {
    logic [KEY_WORD_BITS-1:0] key_lo;
    logic [KEY_WORD_BITS-1:0] key_hi;
    logic [LEN_BITS-1:0]      key_len;
  } cfg_t;

  // One request as held in the input register.
  typedef struct packed {
    logic [7:0] target_byte;
    logic       last_byte;
    logic       no_byte;
  } item_t;

  // One result as held in the output register.
  typedef struct packed {
    logic                    match_found;
    logic [POS_OUT_BITS-1:0] match_position;
    logic                    length_overflow;
  } result_t;

endpackage : smfi_pkg
`default_nettype wire

>>> hdl/smfi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smfi_if
// Valid/ready channel interfaces for target bytes and search results.
// ----------------------------------------------------------------------------

// Target byte channel.
interface smfi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] target_byte;
  logic       last_byte;
  logic       no_byte;

  modport source (output valid, output target_byte, output last_byte, output no_byte,
                  input ready);
  modport sink   (input valid, input target_byte, input last_byte, input no_byte,
                  output ready);
endinterface : smfi_in_if

// Search result channel.
interface smfi_out_if import smfi_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    match_found;
  logic [POS_OUT_BITS-1:0] match_position;
  logic                    length_overflow;

  modport source (output valid, output match_found, output match_position,
                  output length_overflow, input ready);
  modport sink   (input valid, input match_found, input match_position,
                  input length_overflow, output ready);
endinterface : smfi_out_if
`default_nettype wire

>>> hdl/smfi_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smfi_cfg
// APB-style register file holding the search key and its length.
// ----------------------------------------------------------------------------
module smfi_cfg import smfi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready,
  output cfg_t                     cfg
);

  logic [KEY_WORD_BITS-1:0] key_lo_r, key_lo_nxt;
  logic [KEY_WORD_BITS-1:0] key_hi_r, key_hi_nxt;
  logic [LEN_BITS-1:0]      key_len_r, key_len_nxt;
  reg_idx_t                 idx;
  logic                     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_BITS-1:3]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Write decode. Addresses past the last register are dropped.
  always_comb begin
    key_lo_nxt  = key_lo_r;
    key_hi_nxt  = key_hi_r;
    key_len_nxt = key_len_r;
    if (wr_en) begin
      case (idx)
        REG_KEY_LOW: begin
          key_lo_nxt = cfg_pwdata[KEY_WORD_BITS-1:0];
        end
        REG_KEY_HIGH: begin
          key_hi_nxt = cfg_pwdata[KEY_WORD_BITS-1:0];
        end
        REG_KEY_LEN: begin
          key_len_nxt = cfg_pwdata[LEN_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_KEY_LOW:  cfg_prdata = key_lo_r;
      REG_KEY_HIGH: cfg_prdata = key_hi_r;
      REG_KEY_LEN:  cfg_prdata = CFG_DATA_BITS'(key_len_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= '0;
    end else begin
      key_lo_r  <= key_lo_nxt;
      key_hi_r  <= key_hi_nxt;
      key_len_r <= key_len_nxt;
    end
  end

  assign cfg.key_lo  = key_lo_r;
  assign cfg.key_hi  = key_hi_r;
  assign cfg.key_len = key_len_r;

endmodule : smfi_cfg
`default_nettype wire

>>> hdl/smfi_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smfi_in_reg
// Input register stage: captures one request and holds it until the core
// consumes it.
// ----------------------------------------------------------------------------
module smfi_in_reg import smfi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  a_valid,
  output item_t a_item,
  input  logic  a_adv
);

  logic  a_valid_r, a_valid_nxt;
  item_t a_item_r, a_item_nxt;

  // The stage takes a new request when empty or when its content moves on.
  assign in_ready = !a_valid_r || a_adv;

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_item_nxt  = a_item_r;
    if (in_valid && in_ready) begin
      a_valid_nxt = 1'b1;
      a_item_nxt  = in_item;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
    a_item_r <= a_item_nxt;
  end

  assign a_valid = a_valid_r;
  assign a_item  = a_item_r;

endmodule : smfi_in_reg
`default_nettype wire

>>> hdl/smfi_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smfi_core
// Window compare against the key, stream state and the result register.
// ----------------------------------------------------------------------------
module smfi_core import smfi_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    a_valid,
  input  item_t   a_item,
  output logic    a_adv,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int RECENT_DEPTH = (KEY_MAX_BYTES > 1) ? KEY_MAX_BYTES - 1 : 1;
  localparam int CMP_W = ((POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS) + 1;
  localparam logic [POSITION_BITS-1:0] POS_CAP = '1;
  localparam logic [LEN_BITS-1:0]      LEN_CAP = LEN_BITS'(KEY_MAX_BYTES);

  logic [7:0]               recent_r [RECENT_DEPTH];
  logic [7:0]               recent_nxt [RECENT_DEPTH];
  logic [POSITION_BITS-1:0] seen_r, seen_nxt;
  logic                     hit_seen_r, hit_seen_nxt;
  logic [POSITION_BITS-1:0] hit_start_r, hit_start_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     out_valid_r, out_valid_nxt;
  result_t                  out_res_r, out_res_nxt;

  logic [2*KEY_WORD_BITS-1:0] key_vec;
  logic [LEN_BITS-1:0]        len;
  logic                       hit;
  logic                       m;
  logic                       at_cap;
  logic                       over_now;
  logic                       reach;
  logic [CMP_W-1:0]           start_calc;
  logic [POSITION_BITS-1:0]   start;
  logic                       take;
  logic                       new_hit;
  logic                       out_free;
  logic                       emit;
  logic [POSITION_BITS-1:0]   pos_full;
  logic [31:0]                pos_wide;
  result_t                    res;

  assign key_vec = {cfg.key_hi, cfg.key_lo};
  assign len     = (cfg.key_len > LEN_CAP) ? LEN_CAP : cfg.key_len;

  // Parallel compare: for every key length, the newest byte against the last
  // key byte and the stored bytes against the earlier ones. The configured
  // length picks one of the answers.
  always_comb begin
    hit = 1'b0;
    m   = 1'b0;
    for (int l = 1; l <= KEY_MAX_BYTES; l++) begin
      m = (key_vec[8*(l-1) +: 8] == a_item.target_byte);
      for (int i = 0; i < l - 1; i++) begin
        m = m & (key_vec[8*i +: 8] == recent_r[l-2-i]);
      end
      if (len == LEN_BITS'(l)) begin
        hit = m;
      end
    end
  end

  // Position bookkeeping for the byte now in the input register.
  assign at_cap     = (seen_r == POS_CAP);
  assign over_now   = ovf_r || at_cap;
  assign reach      = over_now || ((CMP_W'(seen_r) + CMP_W'(1)) >= CMP_W'(len));
  assign start_calc = CMP_W'(seen_r) + CMP_W'(2) - CMP_W'(len);
  assign start      = over_now ? POS_CAP : start_calc[POSITION_BITS-1:0];

  // Handshake: bytes that end no target never wait on the result register.
  assign out_free = !out_valid_r || out_ready;
  assign a_adv    = a_valid && (!a_item.last_byte || out_free);
  assign take     = a_adv && !a_item.no_byte;
  assign emit     = a_adv && a_item.last_byte;
  assign new_hit  = take && !hit_seen_r && (len != '0) && reach && hit;

  // Stream state update, result assembly and clear at the end of a target.
  always_comb begin
    seen_nxt      = seen_r;
    hit_seen_nxt  = hit_seen_r;
    hit_start_nxt = hit_start_r;
    ovf_nxt       = ovf_r;
    recent_nxt    = recent_r;
    if (take) begin
      seen_nxt = at_cap ? seen_r : seen_r + POSITION_BITS'(1);
      ovf_nxt  = over_now;
      if (new_hit) begin
        hit_seen_nxt  = 1'b1;
        hit_start_nxt = start;
      end
      for (int i = RECENT_DEPTH - 1; i > 0; i--) begin
        recent_nxt[i] = recent_r[i-1];
      end
      recent_nxt[0] = a_item.target_byte;
    end

    if (len == '0) begin
      pos_full = POSITION_BITS'(1);
    end else if (hit_seen_nxt) begin
      pos_full = hit_start_nxt;
    end else begin
      pos_full = '0;
    end
    pos_wide            = 32'(pos_full);
    res.match_found     = (len == '0) || hit_seen_nxt;
    res.match_position  = pos_wide[POS_OUT_BITS-1:0];
    res.length_overflow = ovf_nxt;

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
      seen_nxt      = '0;
      hit_seen_nxt  = 1'b0;
      hit_start_nxt = '0;
      ovf_nxt       = 1'b0;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent_nxt[i] = '0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      hit_seen_r  <= 1'b0;
      hit_start_r <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent_r[i] <= '0;
      end
    end else begin
      seen_r      <= seen_nxt;
      hit_seen_r  <= hit_seen_nxt;
      hit_start_r <= hit_start_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      recent_r    <= recent_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule : smfi_core
`default_nettype wire

>>> hdl/substring_first_match_index_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// substring_first_match_index_unit
// Streaming search for the first occurrence of a configured key.
// ----------------------------------------------------------------------------
// The block takes one target byte per cycle and reports, on the request that
// ends a target, the 1-based start of the first occurrence of the key (0 when
// none, 1 for an empty key). A request passes an input register and one level
// of compare logic into the result register, so the result is offered after
// its last byte moves from the input register into the result register, and
// can be taken at the following clock edge at the earliest. A waiting result
// stalls only a request that ends a target; every other byte keeps flowing at
// one per cycle. The per-byte cost is set by the parallel compare of the
// newest byte and the stored window against all key offsets. Write the key
// registers only while no target is in flight.
// ----------------------------------------------------------------------------
module substring_first_match_index_unit import smfi_pkg::*; #(
  parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  smfi_in_if.sink                  in_chan,
  smfi_out_if.source               out_chan,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   a_item;
  logic    a_valid;
  logic    a_adv;
  logic    in_ready;
  logic    out_valid;
  result_t out_res;

  // Register file.
  smfi_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Input register.
  assign in_item.target_byte = in_chan.target_byte;
  assign in_item.last_byte   = in_chan.last_byte;
  assign in_item.no_byte     = in_chan.no_byte;
  assign in_chan.ready       = in_ready;

  smfi_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .a_valid  (a_valid),
    .a_item   (a_item),
    .a_adv    (a_adv)
  );

  // Compare logic, stream state and result register.
  smfi_core #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .a_valid   (a_valid),
    .a_item    (a_item),
    .a_adv     (a_adv),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.valid           = out_valid;
  assign out_chan.match_found     = out_res.match_found;
  assign out_chan.match_position  = out_res.match_position;
  assign out_chan.length_overflow = out_res.length_overflow;

endmodule : substring_first_match_index_unit
`default_nettype wire

>>> hdl/smfi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smfi_checker
// Port-level checks of the key search unit, bound to the top level.
// ----------------------------------------------------------------------------
module smfi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // The input side only stalls behind a result that is itself stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // A fresh result follows a request that ended a target.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a matching end of target");

endmodule : smfi_checker

bind substring_first_match_index_unit smfi_checker u_smfi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_last   (in_chan.last_byte),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);
`default_nettype wire
